// ----- src/plm_pkg.sv -----
package plm_pkg;

  localparam int unsigned MAX_QUERY = 65535;
  localparam int unsigned TBL_DEPTH = MAX_QUERY + 1;
  localparam int unsigned ADDR_W    = $clog2(TBL_DEPTH);
  // a base prime never exceeds the table bound
  localparam int unsigned BASE_W    = ADDR_W;
  localparam int unsigned MOD_W     = 32;
  localparam int unsigned STEP_W    = $clog2(BASE_W);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [BASE_W-1:0] base_t;
  typedef logic [MOD_W-1:0]  word_t;

  localparam addr_t MAX_ADDR = addr_t'(MAX_QUERY);

  // write port of the prime power table
  typedef struct packed {
    logic  en;
    addr_t addr;
    base_t data;
  } tbl_wr_t;

  typedef enum logic [2:0] {
    SV_CLEAR,
    SV_CHECK,
    SV_MARK,
    SV_POW,
    SV_DONE
  } sieve_st_t;

  typedef enum logic [2:0] {
    WK_IDLE,
    WK_STEP,
    WK_CHK,
    WK_MUL,
    WK_OUT
  } walk_st_t;

endpackage

// ----- src/plm_ram.sv -----
module plm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/plm_mulmod.sv -----
module plm_mulmod (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  plm_pkg::word_t      a,
  input  plm_pkg::base_t      b,
  input  logic [plm_pkg::MOD_W:0] m,
  output logic                done,
  output plm_pkg::word_t      result
);

  localparam int unsigned RW = plm_pkg::MOD_W + 1;
  localparam int unsigned TW = plm_pkg::MOD_W + 2;

  logic                        busy_r, busy_nxt;
  logic [plm_pkg::STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [RW-1:0]               r_r, r_nxt;
  plm_pkg::word_t              a_r;
  plm_pkg::base_t              b_r;
  logic                        done_r, done_nxt;
  logic [TW-1:0]               t, m1, m2;

  // double-and-add, msb of b first; t stays below 3m
  always_comb begin
    m1 = {1'b0, m};
    m2 = {m, 1'b0};
    t  = {r_r, 1'b0} + (b_r[plm_pkg::BASE_W-1] ? {2'b00, a_r} : '0);
    if (t >= m2) begin
      t = t - m2;
    end else if (t >= m1) begin
      t = t - m1;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    r_nxt    = r_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      r_nxt    = '0;
    end else if (busy_r) begin
      r_nxt   = t[RW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == plm_pkg::STEP_W'(plm_pkg::BASE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    r_r   <= r_nxt;
    if (start) begin
      a_r <= a;
      b_r <= b;
    end else if (busy_r) begin
      b_r <= {b_r[plm_pkg::BASE_W-2:0], 1'b0};
    end
  end

  assign done   = done_r;
  assign result = r_r[plm_pkg::MOD_W-1:0];

endmodule

// ----- src/plm_sieve.sv -----
module plm_sieve (
  input  logic             clk,
  input  logic             rst_n,
  output plm_pkg::tbl_wr_t tbl_wr,
  output logic             ready
);

  localparam int unsigned MW = plm_pkg::ADDR_W + 1;

  plm_pkg::sieve_st_t st_r, st_nxt;
  plm_pkg::addr_t     clr_r, clr_nxt;
  plm_pkg::addr_t     i_r, i_nxt;
  logic [MW-1:0]      mult_r, mult_nxt;
  plm_pkg::word_t     pw_r, pw_nxt;

  logic               cw_en, cw_data, comp_rd;
  plm_pkg::addr_t     cw_addr;

  // composite flags; read address follows i_nxt so data matches i_r
  plm_ram #(.WIDTH(1), .DEPTH(plm_pkg::TBL_DEPTH)) u_comp (
    .clk   (clk),
    .we    (cw_en),
    .waddr (cw_addr),
    .wdata (cw_data),
    .raddr (i_nxt),
    .rdata (comp_rd)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      plm_pkg::SV_CLEAR: if (clr_r == plm_pkg::MAX_ADDR) st_nxt = plm_pkg::SV_CHECK;
      plm_pkg::SV_CHECK: begin
        if (!comp_rd) st_nxt = plm_pkg::SV_MARK;
        else if (i_r == plm_pkg::MAX_ADDR) st_nxt = plm_pkg::SV_DONE;
      end
      plm_pkg::SV_MARK: if (mult_r > MW'(plm_pkg::MAX_QUERY)) st_nxt = plm_pkg::SV_POW;
      plm_pkg::SV_POW: begin
        if (pw_r > plm_pkg::word_t'(plm_pkg::MAX_QUERY)) begin
          st_nxt = (i_r == plm_pkg::MAX_ADDR) ? plm_pkg::SV_DONE : plm_pkg::SV_CHECK;
        end
      end
      plm_pkg::SV_DONE:  st_nxt = plm_pkg::SV_DONE;
      default:           st_nxt = plm_pkg::SV_CLEAR;
    endcase
  end

  always_comb begin
    clr_nxt  = clr_r;
    i_nxt    = i_r;
    mult_nxt = mult_r;
    pw_nxt   = pw_r;
    cw_en    = 1'b0;
    cw_addr  = clr_r;
    cw_data  = 1'b0;
    tbl_wr   = '{en: 1'b0, addr: clr_r, data: '0};
    case (st_r)
      plm_pkg::SV_CLEAR: begin
        cw_en     = 1'b1;
        tbl_wr.en = 1'b1;
        clr_nxt   = clr_r + 1'b1;
        i_nxt     = plm_pkg::addr_t'(2);
      end
      plm_pkg::SV_CHECK: begin
        if (!comp_rd) begin
          mult_nxt = {1'b0, i_r} + {1'b0, i_r};
          pw_nxt   = plm_pkg::word_t'(i_r);
        end else if (i_r != plm_pkg::MAX_ADDR) begin
          i_nxt = i_r + 1'b1;
        end
      end
      plm_pkg::SV_MARK: begin
        if (mult_r <= MW'(plm_pkg::MAX_QUERY)) begin
          cw_en    = 1'b1;
          cw_addr  = mult_r[plm_pkg::ADDR_W-1:0];
          cw_data  = 1'b1;
          mult_nxt = mult_r + {1'b0, i_r};
        end
      end
      plm_pkg::SV_POW: begin
        if (pw_r <= plm_pkg::word_t'(plm_pkg::MAX_QUERY)) begin
          tbl_wr = '{en: 1'b1, addr: pw_r[plm_pkg::ADDR_W-1:0],
                     data: plm_pkg::base_t'(i_r)};
          pw_nxt = plm_pkg::word_t'(pw_r[plm_pkg::ADDR_W-1:0] * i_r);
        end else if (i_r != plm_pkg::MAX_ADDR) begin
          i_nxt = i_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= plm_pkg::SV_CLEAR;
      clr_r <= '0;
      i_r   <= plm_pkg::addr_t'(2);
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      i_r   <= i_nxt;
    end
    mult_r <= mult_nxt;
    pw_r   <= pw_nxt;
  end

  assign ready = (st_r == plm_pkg::SV_DONE);

endmodule

// ----- src/prefix_lcm_modulo.sv -----
// walk: queries below 2 go straight to the output stage; otherwise the cursor steps up to k
// (restarting from 1 when k is below it), with a 16-step shift-add modular multiply
// for each prime power met in the table, then a step back to the table
// throughput: one query at a time; a repeat of the last k needs no multiply
// reset: rst_n synchronous; afterwards a clear of all 65536 table entries and a sieve
// pass run before the first query is taken; modulus resets to 1
module prefix_lcm_modulo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [15:0]           in_query_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_lcm_mod,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_modulus
);

  plm_pkg::walk_st_t st_r, st_nxt;
  plm_pkg::addr_t    idx_r, idx_nxt;     // cursor: largest k the product covers
  plm_pkg::addr_t    k_r, k_nxt;
  plm_pkg::word_t    prod_r, prod_nxt;   // lcm(1..cursor) mod m
  plm_pkg::word_t    res_r, res_nxt;
  plm_pkg::word_t    mod_r;
  logic              ov_r, ov_nxt;
  plm_pkg::word_t    out_r, out_nxt;

  plm_pkg::tbl_wr_t  tbl_wr;
  logic              tbl_ready;
  plm_pkg::base_t    base_rd;
  logic              mul_start, mul_done;
  plm_pkg::word_t    mul_res;
  logic              in_beat, out_free;
  plm_pkg::addr_t    k_in;

  plm_sieve u_sieve (
    .clk    (clk),
    .rst_n  (rst_n),
    .tbl_wr (tbl_wr),
    .ready  (tbl_ready)
  );

  // prime power table, read address tracks idx_nxt so base_rd = table[idx_r]
  plm_ram #(.WIDTH(plm_pkg::BASE_W), .DEPTH(plm_pkg::TBL_DEPTH)) u_tbl (
    .clk   (clk),
    .we    (tbl_wr.en),
    .waddr (tbl_wr.addr),
    .wdata (tbl_wr.data),
    .raddr (idx_nxt),
    .rdata (base_rd)
  );

  // zero modulus means 2^32
  plm_mulmod u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (prod_r),
    .b      (base_rd),
    .m      ({mod_r == '0, mod_r}),
    .done   (mul_done),
    .result (mul_res)
  );

  assign in_ready = (st_r == plm_pkg::WK_IDLE) && tbl_ready;
  assign in_beat  = in_valid && in_ready;
  assign out_free = !ov_r || out_ready;
  // saturate k to the table bound
  assign k_in = ({1'b0, in_query_value} > 17'(plm_pkg::MAX_QUERY)) ?
                plm_pkg::MAX_ADDR : plm_pkg::addr_t'(in_query_value);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      plm_pkg::WK_IDLE: begin
        if (in_beat) begin
          st_nxt = (k_in < plm_pkg::addr_t'(2)) ? plm_pkg::WK_OUT : plm_pkg::WK_STEP;
        end
      end
      plm_pkg::WK_STEP: st_nxt = (idx_r == k_r) ? plm_pkg::WK_OUT : plm_pkg::WK_CHK;
      plm_pkg::WK_CHK: begin
        if (base_rd != '0) st_nxt = plm_pkg::WK_MUL;
        else if (idx_r == k_r) st_nxt = plm_pkg::WK_OUT;
      end
      plm_pkg::WK_MUL:  if (mul_done) st_nxt = plm_pkg::WK_STEP;
      plm_pkg::WK_OUT:  if (out_free) st_nxt = plm_pkg::WK_IDLE;
      default:          st_nxt = plm_pkg::WK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    prod_nxt  = prod_r;
    res_nxt   = res_r;
    mul_start = 1'b0;
    ov_nxt    = ov_r && !out_ready;
    out_nxt   = out_r;
    case (st_r)
      plm_pkg::WK_IDLE: begin
        if (in_beat) begin
          k_nxt   = k_in;
          res_nxt = plm_pkg::word_t'(1);   // small query answers 1 unreduced
          if (k_in >= plm_pkg::addr_t'(2) && k_in < idx_r) begin
            idx_nxt  = plm_pkg::addr_t'(1);
            prod_nxt = plm_pkg::word_t'(1);
          end
        end
      end
      plm_pkg::WK_STEP: begin
        if (idx_r == k_r) res_nxt = prod_r;
        else idx_nxt = idx_r + 1'b1;
      end
      plm_pkg::WK_CHK: begin
        if (base_rd != '0) begin
          mul_start = 1'b1;
        end else if (idx_r == k_r) begin
          res_nxt = prod_r;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      plm_pkg::WK_MUL: if (mul_done) prod_nxt = mul_res;
      plm_pkg::WK_OUT: begin
        if (out_free) begin
          ov_nxt  = 1'b1;
          out_nxt = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= plm_pkg::WK_IDLE;
      idx_r  <= plm_pkg::addr_t'(1);
      prod_r <= plm_pkg::word_t'(1);
      mod_r  <= plm_pkg::word_t'(1);
      ov_r   <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      if (cfg_we) begin
        // new modulus restarts the running product
        mod_r  <= cfg_modulus;
        idx_r  <= plm_pkg::addr_t'(1);
        prod_r <= plm_pkg::word_t'(1);
      end else begin
        idx_r  <= idx_nxt;
        prod_r <= prod_nxt;
      end
    end
    k_r   <= k_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid   = ov_r;
  assign out_lcm_mod = out_r;

endmodule

// ----- tb/sv/prefix_lcm_modulo_test.sv -----
`default_nettype none

module prefix_lcm_modulo_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_query_value;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_lcm_mod;
  logic        cfg_we;
  logic [31:0] cfg_modulus;

  prefix_lcm_modulo dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_query_value(in_query_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_lcm_mod   (out_lcm_mod),
    .cfg_we        (cfg_we),
    .cfg_modulus   (cfg_modulus)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // prime power table: entry holds the base prime of p^e, else 0
  plm_pkg::base_t pp_base [0:plm_pkg::MAX_QUERY];
  bit             composite [0:plm_pkg::MAX_QUERY];

  // predictor state, mirrors the block's product and cursor
  plm_pkg::word_t lcm_modulus;
  int unsigned    lcm_cursor;
  plm_pkg::word_t lcm_product;

  logic [15:0]    query_queue[$];
  plm_pkg::word_t lcm_expected[$];
  int             mismatches;
  bit             idle_on;
  bit             in_beat;
  int             in_gap;
  int             out_gap;

  task automatic report_mismatch(input string what, input plm_pkg::word_t got,
                                 input plm_pkg::word_t want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  function automatic void build_table();
    longint unsigned pw;
    for (int i = 0; i <= plm_pkg::MAX_QUERY; i++) begin
      pp_base[i]   = '0;
      composite[i] = 1'b0;
    end
    for (int i = 2; i <= plm_pkg::MAX_QUERY; i++) begin
      if (!composite[i]) begin
        for (int m = 2 * i; m <= plm_pkg::MAX_QUERY; m += i) composite[m] = 1'b1;
        pw = i;
        while (pw <= plm_pkg::MAX_QUERY) begin
          pp_base[pw] = plm_pkg::base_t'(i);
          pw = pw * i;
        end
      end
    end
  endfunction

  // modulus 0 stands for 2^32: plain 32-bit wrap
  function automatic plm_pkg::word_t times_mod(input plm_pkg::word_t a,
                                               input plm_pkg::word_t b);
    longint unsigned p;
    p = longint'(a) * longint'(b);
    if (lcm_modulus == '0) return p[31:0];
    return plm_pkg::word_t'(p % longint'(lcm_modulus));
  endfunction

  function automatic plm_pkg::word_t prefix_lcm(input logic [15:0] k);
    if (k < 2) return 32'd1;           // small query is 1, never reduced
    if (k < lcm_cursor) begin          // below cursor: restart the walk
      lcm_cursor  = 1;
      lcm_product = 32'd1;
    end
    for (int unsigned i = lcm_cursor + 1; i <= k; i++)
      if (pp_base[i] != '0)
        lcm_product = times_mod(lcm_product, plm_pkg::word_t'(pp_base[i]));
    lcm_cursor = k;
    return lcm_product;
  endfunction

  // monitor: sample both channels and the config port at the rising edge
  always @(posedge clk) begin
    in_beat = in_valid && in_ready;
    if (rst_n) begin
      if (cfg_we) begin
        lcm_modulus = cfg_modulus;
        lcm_cursor  = 1;
        lcm_product = 32'd1;
      end
      if (in_beat) lcm_expected = {lcm_expected, prefix_lcm(in_query_value)};
      if (out_valid && out_ready) begin
        if (lcm_expected.size() == 0) begin
          report_mismatch("unexpected beat", out_lcm_mod, 'x);
        end else begin
          plm_pkg::word_t want;
          want = lcm_expected.pop_front();
          if (out_lcm_mod !== want) report_mismatch("lcm_mod", out_lcm_mod, want);
        end
      end
    end
  end

  // driver: queries from the queue, random idle bursts between beats
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_beat)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (query_queue.size() > 0) begin
        in_valid       <= 1'b1;
        in_query_value <= query_queue.pop_front();
        if (idle_on && $urandom_range(3) == 0) in_gap = $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_ready <= 1'b0;
      out_gap--;
    end else begin
      out_ready <= 1'b1;
      if (idle_on && $urandom_range(4) == 0) out_gap = $urandom_range(1, 9);
    end
  end

  task automatic drain();
    while (query_queue.size() > 0 || in_valid || lcm_expected.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_modulus(input plm_pkg::word_t m);
    @(negedge clk);
    cfg_we      <= 1'b1;
    cfg_modulus <= m;
    @(negedge clk);
    cfg_we      <= 1'b0;
  endtask

  // random query runs: mostly small upward steps, with occasional low restarts, small queries and repeats
  task automatic queue_random(input int count);
    int unsigned k;
    k = 0;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0:       k = $urandom_range(0, 255);            // restart low
        1:       k = $urandom_range(0, 3);              // small query
        2:       k = k;                                 // repeat
        default: k = k + $urandom_range(0, 15);         // walk on
      endcase
      if (k > 3000) k = $urandom_range(0, 63);
      query_queue = {query_queue, 16'(k)};
    end
  endtask

  initial begin
    plm_pkg::word_t moduli[$];
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_query_value = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_modulus    = '0;
    idle_on        = 1'b1;
    in_beat        = 1'b0;
    in_gap         = 0;
    out_gap        = 0;
    mismatches     = 0;
    lcm_modulus    = 32'd1;
    lcm_cursor     = 1;
    lcm_product    = 32'd1;
    build_table();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset modulus of 1: everything from 2 up reduces to 0
    query_queue = {query_queue, 16'd0, 16'd1, 16'd2, 16'd1, 16'd6};
    drain();

    // modulus 0: full 32-bit wrap, extremes of the query range
    write_modulus(32'd0);
    query_queue = {query_queue, 16'd2, 16'd3, 16'd4, 16'd8, 16'd16, 16'd9, 16'd7,
                   16'd30, 16'd65535, 16'd65535, 16'd0, 16'd1, 16'd100, 16'd50,
                   16'd50};
    drain();

    moduli = {32'd1, 32'hFFFF_FFFF, 32'd2, 32'd0, 32'h8000_0000, 32'd97,
              $urandom(), $urandom()};
    foreach (moduli[i]) begin
      if (i == moduli.size() - 1) idle_on = 1'b0;   // no idling at the tail
      write_modulus(moduli[i]);
      queue_random(200);
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // overall limit, covers table build after reset and the full walk
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
